// ===== rtl/peqd_pkg.sv =====
`default_nettype none

package peqd_pkg;

   // Command codes of an input transfer.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // Status codes of a result transfer.
   localparam logic [2:0] STATUS_INSERTED = 3'd0;
   localparam logic [2:0] STATUS_DUP      = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_POPPED   = 3'd3;
   localparam logic [2:0] STATUS_QUIT     = 3'd4;
   localparam logic [2:0] STATUS_EMPTY    = 3'd5;

   // Reset value of the quit code register.
   localparam logic [31:0] QUIT_CODE_RESET = 32'hFFFF_FFFF;

   // One queued event.
   typedef struct packed {
      logic [15:0] priority_val;
      logic [7:0]  source_id;
      logic [31:0] event_code;
      logic [31:0] event_param;
   } entry_type;

   // Operation strobes broadcast to every cell of the chain.
   typedef struct packed {
      logic eval_en;
      logic insert_en;
      logic pop_en;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/peqd_req_if.sv =====
`default_nettype none

interface peqd_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  source_id;
   logic [31:0] event_code;
   logic [31:0] event_param;
   logic [15:0] priority_req;
   logic        unique_only;

   modport source (
      output valid, command, source_id, event_code, event_param, priority_req, unique_only,
      input  ready
   );

   modport sink (
      input  valid, command, source_id, event_code, event_param, priority_req, unique_only,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/peqd_rsp_if.sv =====
`default_nettype none

interface peqd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_source;
   logic [31:0] out_code;
   logic [31:0] out_param;

   modport source (
      output valid, status, out_source, out_code, out_param,
      input  ready
   );

   modport sink (
      input  valid, status, out_source, out_code, out_param,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/peqd_cell.sv =====
`default_nettype none

module peqd_cell
   import peqd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     item,
   input  wire logic          left_keep,
   input  wire entry_type     left_entry,
   input  wire logic          left_valid,
   input  wire entry_type     right_entry,
   input  wire logic          right_valid,
   output entry_type          entry,
   output logic               valid,
   output logic               keep,
   output logic               match
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      keep_ff,  keep_in;
   logic      match_ff, match_in;

   // Compare against the pending event, and pick the next content of the cell.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      keep_in  = keep_ff;
      match_in = match_ff;
      if (ctrl.eval_en) begin
         // The cell stays in place when it holds an event of priority at or above the new one.
         keep_in  = valid_ff && (entry_ff.priority_val >= item.priority_val);
         match_in = valid_ff && (entry_ff.priority_val == item.priority_val) &&
                    (entry_ff.source_id == item.source_id) &&
                    (entry_ff.event_code == item.event_code);
      end
      if (ctrl.insert_en && !keep_ff) begin
         if (left_keep) begin
            // First cell past the kept prefix takes the new event.
            entry_in = item;
            valid_in = 1'b1;
         end else begin
            entry_in = left_entry;
            valid_in = left_valid;
         end
      end
      if (ctrl.pop_en) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   // Control flags are cleared by reset; the stored event is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         keep_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         keep_ff  <= keep_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign keep  = keep_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ===== rtl/priority_event_queue_dedup.sv =====
`default_nettype none

// Bounded event queue of DEPTH entries held in a chain of cells, sorted by priority with the
// highest at the head and first-in-first-out among equal priorities. One request is taken at a
// time. An insert passes through two states after its transfer: an evaluate state in which
// every cell compares itself with the new event and registers its keep and duplicate flags,
// and an apply state in which the duplicate and full checks resolve, the chain shifts right
// behind the insertion point and the result is registered. A pop goes from its transfer
// straight to the apply state, in which the chain shifts left and the head is returned. The
// result sits in an output register; the next request is taken once the block is back in
// idle, which it reaches only after its result has moved to that register, so a stalled
// result holds the block in its apply state for as long as the stall lasts.
// The quit code register is written through csr_write_en and csr_write_data.
module priority_event_queue_dedup
   import peqd_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_write_en,
   input  wire logic [31:0] csr_write_data,
   peqd_req_if.sink   req_ch,
   peqd_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY
   } state_type;

   state_type     state_ff, state_in;
   logic          cmd_ff, cmd_in;
   logic          unique_ff, unique_in;
   entry_type     item_ff, item_in;
   logic [31:0]   quit_code_ff, quit_code_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   entry_type     out_ff, out_in;

   cell_ctrl_type ctrl;
   entry_type     cell_entry [DEPTH];
   logic          cell_valid [DEPTH];
   logic          cell_keep  [DEPTH];
   logic [DEPTH-1:0] match_vec;

   logic out_free;
   logic is_dup;
   logic is_full;
   logic is_empty;
   logic apply_go;

   // Chain of cells; each one sees its neighbors on both sides.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_valid;
      logic      left_keep;
      entry_type right_entry;
      logic      right_valid;
      logic      cell_match;

      if (i == 0) begin : g_head
         assign left_entry = item_ff;
         assign left_valid = 1'b0;
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_next
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end

      peqd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .item        (item_ff),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .keep        (cell_keep[i]),
         .match       (cell_match)
      );

      assign match_vec[i] = cell_match;
   end

   // Queue status: duplicate from the match flags of every cell, full and empty from the ends of the chain.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign is_dup   = unique_ff && (|match_vec);
   assign is_full  = cell_valid[DEPTH-1];
   assign is_empty = !cell_valid[0];
   assign apply_go = (state_ff == ST_APPLY) && out_free;

   // Strobes to the cells.
   always_comb begin
      ctrl.eval_en   = (state_ff == ST_EVAL);
      ctrl.insert_en = apply_go && (cmd_ff == CMD_INSERT) && !is_dup && !is_full;
      ctrl.pop_en    = apply_go && (cmd_ff == CMD_POP) && !is_empty;
   end

   // Sequencer, request latch, result register and quit code register.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      unique_in    = unique_ff;
      item_in      = item_ff;
      quit_code_in = quit_code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      out_in       = out_ff;

      if (csr_write_en) begin
         quit_code_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in                = req_ch.command;
               unique_in             = req_ch.unique_only;
               item_in.priority_val  = req_ch.priority_req;
               item_in.source_id     = req_ch.source_id;
               item_in.event_code    = req_ch.event_code;
               item_in.event_param   = req_ch.event_param;
               state_in = (req_ch.command == CMD_POP) ? ST_APPLY : ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_in       = '0;
               state_in     = ST_IDLE;
               if (cmd_ff == CMD_INSERT) begin
                  if (is_dup) begin
                     status_in = STATUS_DUP;
                  end else if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in = STATUS_INSERTED;
                  end
               end else if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  out_in    = cell_entry[0];
                  status_in = (cell_entry[0].event_code == quit_code_ff) ?
                              STATUS_QUIT : STATUS_POPPED;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         quit_code_ff <= QUIT_CODE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         quit_code_ff <= quit_code_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      unique_ff <= unique_in;
      item_ff   <= item_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   // Port drive.
   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.out_source = out_ff.source_id;
   assign rsp_ch.out_code   = out_ff.event_code;
   assign rsp_ch.out_param  = out_ff.event_param;

endmodule

`default_nettype wire

// ===== verif/priority_event_queue_dedup_test.sv =====
`timescale 1ns / 1ps

module priority_event_queue_dedup_test;
   import peqd_pkg::*;

   localparam int QUEUE_DEPTH = 64;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 250;
   localparam int CYCLE_LIMIT = 1000000;

   // One request as it appears on the input channel.
   typedef struct packed {
      logic        command;
      logic [7:0]  source_id;
      logic [31:0] event_code;
      logic [31:0] event_param;
      logic [15:0] priority_req;
      logic        unique_only;
   } request_type;

   // One result as it appears on the result channel.
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_source;
      logic [31:0] out_code;
      logic [31:0] out_param;
   } outcome_type;

   // Mirror of the sorted queue plus the outcomes still owed by the block.
   class event_queue_tracker;
      entry_type   queued_events[$];
      outcome_type pending_outcomes[$];
      logic [31:0] quit_code;
      int          mismatches;

      function new();
         quit_code  = QUIT_CODE_RESET;
         mismatches = 0;
      endfunction

      // Apply an accepted request to the mirror and record the outcome it must produce.
      function void note_request(request_type r);
         outcome_type want;
         entry_type   head;
         entry_type   fresh;
         int          pos;
         bit          duplicate;

         want      = '0;
         duplicate = 1'b0;
         if (r.command == CMD_INSERT) begin
            // The duplicate check wins over the full check.
            if (r.unique_only) begin
               foreach (queued_events[i]) begin
                  if (queued_events[i].priority_val == r.priority_req &&
                      queued_events[i].source_id == r.source_id &&
                      queued_events[i].event_code == r.event_code)
                     duplicate = 1'b1;
               end
            end
            if (duplicate) begin
               want.status = STATUS_DUP;
            end else if (queued_events.size() >= QUEUE_DEPTH) begin
               want.status = STATUS_FULL;
            end else begin
               // New events go behind every entry of equal or higher priority.
               pos = 0;
               while (pos < queued_events.size() &&
                      queued_events[pos].priority_val >= r.priority_req)
                  pos++;
               fresh.priority_val = r.priority_req;
               fresh.source_id    = r.source_id;
               fresh.event_code   = r.event_code;
               fresh.event_param  = r.event_param;
               queued_events.insert(pos, fresh);
               want.status = STATUS_INSERTED;
            end
         end else if (queued_events.size() == 0) begin
            want.status = STATUS_EMPTY;
         end else begin
            head            = queued_events.pop_front();
            want.status     = (head.event_code == quit_code) ? STATUS_QUIT : STATUS_POPPED;
            want.out_source = head.source_id;
            want.out_code   = head.event_code;
            want.out_param  = head.event_param;
         end
         pending_outcomes.push_back(want);
      endfunction

      // Compare a result transfer with the oldest outstanding outcome.
      function void check_outcome(outcome_type got);
         outcome_type want;

         if (pending_outcomes.size() == 0) begin
            mismatches++;
            $display("%0t: result with none outstanding, status %0d", $time, got.status);
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         end
         if (got.out_source !== want.out_source) begin
            mismatches++;
            $display("%0t: out_source expected %h actual %h", $time, want.out_source,
                     got.out_source);
         end
         if (got.out_code !== want.out_code) begin
            mismatches++;
            $display("%0t: out_code expected %h actual %h", $time, want.out_code,
                     got.out_code);
         end
         if (got.out_param !== want.out_param) begin
            mismatches++;
            $display("%0t: out_param expected %h actual %h", $time, want.out_param,
                     got.out_param);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [31:0] csr_write_data;
   bit          quiet;
   int          cycle_count;

   peqd_req_if req_ch ();
   peqd_rsp_if rsp_ch ();

   event_queue_tracker tracker = new();

   priority_event_queue_dedup #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Observe both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            tracker.note_request({req_ch.command, req_ch.source_id, req_ch.event_code,
                                  req_ch.event_param, req_ch.priority_req,
                                  req_ch.unique_only});
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_outcome({rsp_ch.status, rsp_ch.out_source, rsp_ch.out_code,
                                   rsp_ch.out_param});
      end
   end

   // Idle length: mostly none or short, now and then long, none at all in quiet phases.
   function automatic int idle_len();
      int r;

      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic request_type build_request(logic cmd, logic [7:0] src,
                                                 logic [31:0] code, logic [31:0] param,
                                                 logic [15:0] prio, logic uniq);
      request_type r;

      r.command      = cmd;
      r.source_id    = src;
      r.event_code   = code;
      r.event_param  = param;
      r.priority_req = prio;
      r.unique_only  = uniq;
      return r;
   endfunction

   // Random request; sources, codes and priorities come mostly from small pools so that
   // duplicates, equal-priority ties and quit codes show up often.
   function automatic request_type random_request(int insert_pct);
      request_type r;

      r.command   = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP;
      r.source_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: begin
            r.event_code = $urandom;
         end
         1: begin
            r.event_code = tracker.quit_code;
         end
         default: begin
            r.event_code = $urandom_range(0, 3);
         end
      endcase
      r.event_param = $urandom;
      if ($urandom_range(0, 3) == 0)
         r.priority_req = 16'($urandom);
      else
         r.priority_req = {2'($urandom_range(0, 3)), 14'h0};
      r.unique_only = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Present one request after an optional gap and hold it until the transfer.
   task automatic send_request(request_type r);
      int gap;

      gap = idle_len();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.command      <= r.command;
      req_ch.source_id    <= r.source_id;
      req_ch.event_code   <= r.event_code;
      req_ch.event_param  <= r.event_param;
      req_ch.priority_req <= r.priority_req;
      req_ch.unique_only  <= r.unique_only;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering requests and wait for every outstanding result.
   task automatic drain_queue();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_quit_code(logic [31:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      tracker.quit_code = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Result side: random stalls between transfers.
   initial begin
      int gap;

      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         gap = idle_len();
         repeat (gap) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      logic [31:0] next_quit;

      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = '0;
      quiet               = 1'b0;
      cycle_count         = 0;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_INSERT;
      req_ch.source_id    = '0;
      req_ch.event_code   = '0;
      req_ch.event_param  = '0;
      req_ch.priority_req = '0;
      req_ch.unique_only  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the quit code at its reset value: empty pop, field extremes,
      // duplicate drops, ties kept in arrival order, and quit events at the head.
      send_request(build_request(CMD_POP, 8'h00, '0, '0, '0, 1'b0));
      send_request(build_request(CMD_INSERT, 8'h00, '0, '0, 16'h0000, 1'b0));
      send_request(build_request(CMD_INSERT, 8'hFF, '1, '1, 16'hFFFF, 1'b1));
      send_request(build_request(CMD_INSERT, 8'hFF, '1, 32'h1, 16'hFFFF, 1'b1));
      send_request(build_request(CMD_INSERT, 8'hFE, '1, 32'h2, 16'hFFFF, 1'b1));
      send_request(build_request(CMD_INSERT, 8'hFF, '1, 32'h3, 16'hFFFE, 1'b1));
      send_request(build_request(CMD_INSERT, 8'h00, '0, 32'h5, 16'h0000, 1'b0));
      send_request(build_request(CMD_INSERT, 8'h00, '0, 32'h6, 16'h0000, 1'b1));
      send_request(build_request(CMD_INSERT, 8'h5A, 32'h1234_5678, 32'hA5A5_A5A5, 16'h8000,
                                 1'b0));
      send_request(build_request(CMD_INSERT, 8'hA5, 32'hEDCB_A987, 32'h5A5A_5A5A, 16'h7FFF,
                                 1'b1));
      repeat (8) send_request(build_request(CMD_POP, 8'hFF, '1, '1, 16'hFFFF, 1'b1));
      drain_queue();

      // Random phases: fill-biased and drain-biased in turn, each under its own quit code.
      // The sender stops between phases until every result has come back.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               next_quit = 32'h0000_0000;
            end
            1: begin
               next_quit = 32'hFFFF_FFFF;
            end
            default: begin
               next_quit = $urandom;
            end
         endcase
         write_quit_code(next_quit);
         quiet = (phase % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_request(random_request((phase % 2 == 0) ? 80 : 25));
         drain_queue();
      end

      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
